/* rtl/blt_pkg.sv */
package blt_pkg;

	localparam int unsigned MOLECULES_DEF = 256;
	localparam int unsigned MAX_BONDS_DEF = 1024;
	localparam int unsigned HIST_BINS_DEF = 16384;

	localparam int unsigned KEY_W  = 16;
	localparam int unsigned LIFE_W = 14;
	localparam int unsigned HIST_W = 32;

	localparam logic [LIFE_W-1:0] LIFE_MAX = '1;
	localparam logic [HIST_W-1:0] HIST_MAX = '1;

	localparam logic OP_ENTRY = 1'b0;
	localparam logic OP_HIST  = 1'b1;

	localparam logic KIND_OVERLAP = 1'b0;
	localparam logic KIND_HIST    = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_CMP,
		ST_TAB,
		ST_TUSE,
		ST_HUSE,
		ST_EMIT
	} blt_state_t;

	typedef enum logic [1:0] {
		ACT_BRK,
		ACT_INC,
		ACT_NEW
	} blt_act_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} blt_bond_req_t;

	typedef struct packed {
		logic              clr;
		logic              rd;
		logic              wr;
		logic [LIFE_W-1:0] wdata;
	} blt_tab_req_t;

	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [HIST_W-1:0] wdata;
	} blt_hist_req_t;

endpackage

/* rtl/bond_lifetime_merge_tracker_core.sv */
// Histogram read: result registered in EMIT before the next request. Bond entry: FETCH
// through HUSE per bond broken, through TUSE for a match, through TAB for a new bond (no
// CMP once the previous list is used up); frame end adds the break steps per leftover
// plus FETCH, EMIT, held while an earlier result waits. Single-port table RMW sets these.
// Reset (arst_n low) clears control at once; a clearing pass then zeroes both tables over
// max(MOLECULES*MOLECULES, HIST_BINS) addresses; no request is taken meanwhile.
module bond_lifetime_merge_tracker_core #(
	parameter int unsigned MOLECULES = blt_pkg::MOLECULES_DEF,
	parameter int unsigned MAX_BONDS = blt_pkg::MAX_BONDS_DEF,
	parameter int unsigned HIST_BINS = blt_pkg::HIST_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // site_a[7:0], site_b[15:8], bin_index[29:16], zero fill
	input  logic        s_tuser,   // opcode
	input  logic        s_tlast,   // last_in_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // value[31:0], overflow[32], zero fill
	output logic        m_tuser    // kind
);

	localparam int unsigned TS    = MOLECULES * MOLECULES;
	localparam int unsigned TW    = $clog2(TS);
	localparam int unsigned HW    = $clog2(HIST_BINS);
	localparam int unsigned AW    = $clog2(MAX_BONDS);
	localparam int unsigned LW    = $clog2(MAX_BONDS + 1);
	localparam int unsigned CLR_N = (TS > HIST_BINS) ? TS : HIST_BINS;
	localparam int unsigned CW    = $clog2(CLR_N);

	localparam logic [LW-1:0] MAX_L     = LW'(MAX_BONDS);
	localparam logic [16:0]   BINS_17   = 17'(HIST_BINS);
	localparam logic [HW-1:0] BIN_TOP   = HW'(HIST_BINS - 1);
	localparam logic [CW:0]   TS_C      = (CW+1)'(TS);
	localparam logic [CW:0]   BINS_C    = (CW+1)'(HIST_BINS);
	localparam logic [CW-1:0] CLR_LAST  = CW'(CLR_N - 1);

	// Control state
	blt_pkg::blt_state_t st_q, st_nxt;
	blt_pkg::blt_act_t   act_q;
	logic [CW-1:0]       clr_cnt_q;
	logic                prev_bank_q;
	logic [LW-1:0]       prev_len_q;
	logic [LW-1:0]       curr_len_q;
	logic [LW-1:0]       ptr_q;
	logic [LW-1:0]       overlap_q;
	logic                ovf_q;
	logic                drain_q;
	logic                out_valid_q;

	// Payload held for the request in progress
	logic [blt_pkg::KEY_W-1:0] key_q;
	logic [blt_pkg::KEY_W-1:0] sel_key_q;
	logic                      last_q;
	logic                      kind_q;
	logic                      bin_ok_q;
	logic [HW-1:0]             hbin_q;
	logic [31:0]               out_value_q;
	logic                      out_ovf_q;
	logic                      out_kind_q;

	// Memory requests and read data
	blt_pkg::blt_bond_req_t     bond_req;
	blt_pkg::blt_tab_req_t      tab_req;
	blt_pkg::blt_hist_req_t     hist_req;
	logic [blt_pkg::KEY_W-1:0]  prev_key;
	logic [blt_pkg::LIFE_W-1:0] life_rd;
	logic [blt_pkg::HIST_W-1:0] hist_rd;
	logic [HW-1:0]              hist_addr;

	// Derived terms
	logic                      in_acc;
	logic                      is_entry;
	logic                      room;
	logic                      have_prev;
	logic                      clr_last;
	logic                      out_free;
	logic [blt_pkg::KEY_W-1:0] in_key;
	logic [16:0]               bin_ext;
	logic [16:0]               life_ext;
	logic [HW-1:0]             life_bin;
	logic                      bin_ok;
	logic                      finish;
	logic [31:0]               emit_value;

	assign s_tready  = (st_q == blt_pkg::ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign is_entry  = (s_tuser == blt_pkg::OP_ENTRY);
	assign room      = (curr_len_q < MAX_L);
	assign have_prev = (ptr_q < prev_len_q);
	assign clr_last  = (clr_cnt_q == CLR_LAST);
	assign out_free  = !out_valid_q || m_tready;
	assign in_key    = {s_tdata[7:0], s_tdata[15:8]};
	assign bin_ext   = {3'b000, s_tdata[29:16]};
	assign bin_ok    = (bin_ext < BINS_17);

	// Clamp a broken bond's lifetime into the top bin
	assign life_ext = {3'b000, life_rd};
	assign life_bin = (life_ext >= BINS_17) ? BIN_TOP : life_ext[HW-1:0];

	// Merge step of the current entry ends: drain leftovers on the last one
	assign finish = ((st_q == blt_pkg::ST_TAB) && (act_q == blt_pkg::ACT_NEW))
		|| ((st_q == blt_pkg::ST_TUSE) && (act_q == blt_pkg::ACT_INC));

	assign emit_value = (kind_q == blt_pkg::KIND_HIST)
		? (bin_ok_q ? hist_rd : 32'd0)
		: 32'(overlap_q);

	// Next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			blt_pkg::ST_CLEAR: begin
				if (clr_last) st_nxt = blt_pkg::ST_IDLE;
			end
			blt_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (!is_entry) st_nxt = blt_pkg::ST_EMIT;
					else if (room || s_tlast) st_nxt = blt_pkg::ST_FETCH;
				end
			end
			blt_pkg::ST_FETCH: begin
				if (have_prev) st_nxt = blt_pkg::ST_CMP;
				else if (drain_q) st_nxt = blt_pkg::ST_EMIT;
				else st_nxt = blt_pkg::ST_TAB;
			end
			blt_pkg::ST_CMP: st_nxt = blt_pkg::ST_TAB;
			blt_pkg::ST_TAB: begin
				if (act_q == blt_pkg::ACT_NEW)
					st_nxt = last_q ? blt_pkg::ST_FETCH : blt_pkg::ST_IDLE;
				else
					st_nxt = blt_pkg::ST_TUSE;
			end
			blt_pkg::ST_TUSE: begin
				if (act_q == blt_pkg::ACT_BRK) st_nxt = blt_pkg::ST_HUSE;
				else st_nxt = last_q ? blt_pkg::ST_FETCH : blt_pkg::ST_IDLE;
			end
			blt_pkg::ST_HUSE: st_nxt = blt_pkg::ST_FETCH;
			blt_pkg::ST_EMIT: begin
				if (out_free) st_nxt = blt_pkg::ST_IDLE;
			end
			default: st_nxt = blt_pkg::ST_CLEAR;
		endcase
	end

	// Memory requests
	always_comb begin
		bond_req    = '0;
		tab_req     = '0;
		hist_req    = '0;
		hist_addr   = hbin_q;
		bond_req.rd = (st_q == blt_pkg::ST_FETCH) && have_prev;
		bond_req.wr = in_acc && is_entry && room;
		unique case (st_q)
			blt_pkg::ST_CLEAR: begin
				tab_req.clr    = ({1'b0, clr_cnt_q} < TS_C);
				tab_req.wr     = tab_req.clr;
				hist_req.wr    = ({1'b0, clr_cnt_q} < BINS_C);
				hist_addr      = clr_cnt_q[HW-1:0];
			end
			blt_pkg::ST_IDLE: begin
				hist_req.rd    = in_acc && !is_entry && bin_ok;
				hist_addr      = bin_ext[HW-1:0];
			end
			blt_pkg::ST_TAB: begin
				tab_req.rd     = (act_q != blt_pkg::ACT_NEW);
				tab_req.wr     = (act_q == blt_pkg::ACT_NEW);
				tab_req.wdata  = blt_pkg::LIFE_W'(1);
			end
			blt_pkg::ST_TUSE: begin
				tab_req.wr     = 1'b1;
				if (act_q == blt_pkg::ACT_INC) begin
					tab_req.wdata = (life_rd == blt_pkg::LIFE_MAX) ? life_rd : life_rd + 1'b1;
				end else begin
					hist_req.rd   = 1'b1;
					hist_addr     = life_bin;
				end
			end
			blt_pkg::ST_HUSE: begin
				hist_req.wr    = 1'b1;
				hist_req.wdata = (hist_rd == blt_pkg::HIST_MAX) ? hist_rd : hist_rd + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= blt_pkg::ST_CLEAR;
			act_q       <= blt_pkg::ACT_NEW;
			clr_cnt_q   <= '0;
			prev_bank_q <= 1'b0;
			prev_len_q  <= '0;
			curr_len_q  <= '0;
			ptr_q       <= '0;
			overlap_q   <= '0;
			ovf_q       <= 1'b0;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (st_q == blt_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;

			// Advance the collected list; drop entries beyond the buffer
			if (in_acc && is_entry) begin
				if (room) curr_len_q <= curr_len_q + 1'b1;
				else ovf_q <= 1'b1;
				if (!room && s_tlast) drain_q <= 1'b1;
			end

			if (st_q == blt_pkg::ST_FETCH) act_q <= blt_pkg::ACT_NEW;

			// Choose the step for the head of the previous list
			if (st_q == blt_pkg::ST_CMP) begin
				if (drain_q || (prev_key < key_q)) begin
					act_q <= blt_pkg::ACT_BRK;
					ptr_q <= ptr_q + 1'b1;
				end else if (prev_key == key_q) begin
					act_q     <= blt_pkg::ACT_INC;
					ptr_q     <= ptr_q + 1'b1;
					overlap_q <= overlap_q + 1'b1;
				end else begin
					act_q <= blt_pkg::ACT_NEW;
				end
			end

			if (finish && last_q) drain_q <= 1'b1;

			// Hand over a result; close the frame when it is the overlap count
			if ((st_q == blt_pkg::ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
				if (kind_q == blt_pkg::KIND_OVERLAP) begin
					prev_bank_q <= ~prev_bank_q;
					prev_len_q  <= curr_len_q;
					curr_len_q  <= '0;
					ptr_q       <= '0;
					overlap_q   <= '0;
					ovf_q       <= 1'b0;
					drain_q     <= 1'b0;
				end
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q    <= in_key;
			last_q   <= s_tlast;
			bin_ok_q <= bin_ok;
			kind_q   <= is_entry ? blt_pkg::KIND_OVERLAP : blt_pkg::KIND_HIST;
		end
		if (st_q == blt_pkg::ST_FETCH) sel_key_q <= key_q;
		if ((st_q == blt_pkg::ST_CMP) && (drain_q || (prev_key < key_q))) sel_key_q <= prev_key;
		if (st_q == blt_pkg::ST_TUSE) hbin_q <= life_bin;
		if ((st_q == blt_pkg::ST_EMIT) && out_free) begin
			out_value_q <= emit_value;
			out_ovf_q   <= (kind_q == blt_pkg::KIND_OVERLAP) ? ovf_q : 1'b0;
			out_kind_q  <= kind_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_ovf_q, out_value_q};
	assign m_tuser  = out_kind_q;

	blt_bond_list #(
		.MAX_BONDS(MAX_BONDS)
	) u_bond_list (
		.clk      (clk),
		.prev_bank(prev_bank_q),
		.req      (bond_req),
		.wr_addr  (curr_len_q[AW-1:0]),
		.wr_key   (in_key),
		.rd_addr  (ptr_q[AW-1:0]),
		.rd_key   (prev_key)
	);

	blt_life_table #(
		.MOLECULES(MOLECULES)
	) u_life_table (
		.clk     (clk),
		.req     (tab_req),
		.key     (sel_key_q),
		.clr_addr(clr_cnt_q[TW-1:0]),
		.rdata   (life_rd)
	);

	blt_hist #(
		.HIST_BINS(HIST_BINS)
	) u_hist (
		.clk  (clk),
		.req  (hist_req),
		.addr (hist_addr),
		.rdata(hist_rd)
	);

endmodule

/* rtl/blt_bond_list.sv */
module blt_bond_list #(
	parameter int unsigned MAX_BONDS = blt_pkg::MAX_BONDS_DEF,
	localparam int unsigned AW = $clog2(MAX_BONDS)
) (
	input  logic                       clk,
	input  logic                       prev_bank,
	input  blt_pkg::blt_bond_req_t     req,
	input  logic [AW-1:0]              wr_addr,
	input  logic [blt_pkg::KEY_W-1:0]  wr_key,
	input  logic [AW-1:0]              rd_addr,
	output logic [blt_pkg::KEY_W-1:0]  rd_key
);

	// Two banks: the previous frame's list and the one being collected
	logic [blt_pkg::KEY_W-1:0] mem [2*MAX_BONDS];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[{~prev_bank, wr_addr}] <= wr_key;
		end
		if (req.rd) begin
			rd_key <= mem[{prev_bank, rd_addr}];
		end
	end

endmodule

/* rtl/blt_life_table.sv */
module blt_life_table #(
	parameter int unsigned MOLECULES = blt_pkg::MOLECULES_DEF,
	localparam int unsigned TS = MOLECULES * MOLECULES,
	localparam int unsigned TW = $clog2(TS)
) (
	input  logic                       clk,
	input  blt_pkg::blt_tab_req_t      req,
	input  logic [blt_pkg::KEY_W-1:0]  key,
	input  logic [TW-1:0]              clr_addr,
	output logic [blt_pkg::LIFE_W-1:0] rdata
);

	localparam logic [TW:0] TS_W = (TW+1)'(TS);
	localparam logic [TW:0] MOL_W = (TW+1)'(MOLECULES);

	// Reduce a byte modulo a constant, one restoring step per bit
	function automatic logic [7:0] mod_small(input logic [7:0] v, input int unsigned c);
		logic [31:0] r;
		r = 32'(v);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (32'(c) << k)) begin
				r = r - (32'(c) << k);
			end
		end
		return r[7:0];
	endfunction

	logic [blt_pkg::LIFE_W-1:0] mem [TS];
	logic [7:0]                 a_mod;
	logic [7:0]                 b_mod;
	logic [TW:0]                sum;
	logic [TW-1:0]              idx;
	logic [TW-1:0]              addr;

	always_comb begin
		a_mod = mod_small(key[15:8], TS);
		b_mod = mod_small(key[7:0], MOLECULES);
		sum   = (TW+1)'(a_mod) + (TW+1)'(b_mod) * MOL_W;
		if (sum >= TS_W) begin
			sum = sum - TS_W;
		end
		idx  = sum[TW-1:0];
		addr = req.clr ? clr_addr : idx;
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* rtl/blt_hist.sv */
module blt_hist #(
	parameter int unsigned HIST_BINS = blt_pkg::HIST_BINS_DEF,
	localparam int unsigned HW = $clog2(HIST_BINS)
) (
	input  logic                       clk,
	input  blt_pkg::blt_hist_req_t     req,
	input  logic [HW-1:0]              addr,
	output logic [blt_pkg::HIST_W-1:0] rdata
);

	logic [blt_pkg::HIST_W-1:0] mem [HIST_BINS];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* test/tb_top.sv */
module tb_top;

	// Idle cycles with no request moving either way before the run is abandoned; covers
	// the table clearing pass after reset and the longest frame-end drain.
	localparam int unsigned WATCHDOG_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES    = 600;
	localparam int unsigned DRAIN_CYCLES   = 64;
	localparam int unsigned PHASE_ITEMS    = 120;
	localparam int unsigned FRAME_CAP      = 48;

	typedef enum logic [1:0] {
		PACE_FREE,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic        overflow;
	} bond_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // site_a[7:0], site_b[15:8], bin_index[29:16], zero fill
	logic        s_tuser;   // opcode
	logic        s_tlast;   // last_in_frame
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // value[31:0], overflow[32], zero fill
	logic        m_tuser;   // kind

	pace_t       pace = PACE_FREE;
	logic        hold_req = 1'b0;
	logic        hold_ack = 1'b0;
	int unsigned hold_left = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatch_count = 0;
	int unsigned results_seen = 0;

	// Shadow copy of the tracker: lifetime table indexed {site_b, site_a}, histogram,
	// and the two bond lists that swap roles at every frame end.
	bit [blt_pkg::LIFE_W-1:0] life_tab [0:blt_pkg::MOLECULES_DEF*blt_pkg::MOLECULES_DEF-1];
	bit [blt_pkg::HIST_W-1:0] life_hist [0:blt_pkg::HIST_BINS_DEF-1];
	bit [blt_pkg::KEY_W-1:0]  bond_bank [0:1][0:blt_pkg::MAX_BONDS_DEF-1];
	bit              prev_sel;
	int unsigned     prev_len;
	int unsigned     curr_len;
	int unsigned     prev_ptr;
	int unsigned     overlap_tally;
	bit              dropped_entries;

	bond_result_t             pending_results [$];
	bit [blt_pkg::KEY_W-1:0]  prior_frame [$];

	bond_lifetime_merge_tracker_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	// Close a bond: count its lifetime in the histogram and clear its counter.
	// A 14-bit lifetime never exceeds the last bin, so no clamp is needed at these sizes.
	function automatic void retire_bond(bit [blt_pkg::KEY_W-1:0] key);
		bit [15:0] slot;
		bit [13:0] bin;
		slot = {key[7:0], key[15:8]};
		bin  = life_tab[slot];
		if (life_hist[bin] != blt_pkg::HIST_MAX)
			life_hist[bin] = life_hist[bin] + 1;
		life_tab[slot] = '0;
	endfunction

	// Merge one bond entry against the previous list; at the frame mark, retire what is
	// left of the previous list, queue the overlap count and swap the lists.
	function automatic void merge_bond_entry(bit [blt_pkg::KEY_W-1:0] key, bit frame_end);
		bit [15:0] slot;
		bond_result_t res;
		slot = {key[7:0], key[15:8]};
		if (curr_len < blt_pkg::MAX_BONDS_DEF) begin
			while (prev_ptr < prev_len && bond_bank[prev_sel][prev_ptr] < key) begin
				retire_bond(bond_bank[prev_sel][prev_ptr]);
				prev_ptr++;
			end
			if (prev_ptr < prev_len && bond_bank[prev_sel][prev_ptr] == key) begin
				if (life_tab[slot] != blt_pkg::LIFE_MAX)
					life_tab[slot] = life_tab[slot] + 1;
				prev_ptr++;
				overlap_tally++;
			end else begin
				life_tab[slot] = 1;
			end
			bond_bank[!prev_sel][curr_len] = key;
			curr_len++;
		end else begin
			dropped_entries = 1'b1;
		end
		if (frame_end) begin
			while (prev_ptr < prev_len) begin
				retire_bond(bond_bank[prev_sel][prev_ptr]);
				prev_ptr++;
			end
			res.kind     = blt_pkg::KIND_OVERLAP;
			res.value    = overlap_tally;
			res.overflow = dropped_entries;
			pending_results.insert(pending_results.size(), res);
			prev_sel        = !prev_sel;
			prev_len        = curr_len;
			curr_len        = 0;
			prev_ptr        = 0;
			overlap_tally   = 0;
			dropped_entries = 1'b0;
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	// Offer one request, hold it until taken, predict, then maybe idle under a gapped pace.
	task automatic send_item(logic op, logic [7:0] site_a, logic [7:0] site_b,
			logic frame_end, logic [13:0] bin);
		int unsigned gap;
		bond_result_t res;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tlast  <= frame_end;
		s_tdata  <= {2'b00, bin, site_b, site_a};
		do
			@(posedge clk);
		while (!s_tready);
		if (op == blt_pkg::OP_HIST) begin
			res.kind     = blt_pkg::KIND_HIST;
			res.value    = life_hist[bin];
			res.overflow = 1'b0;
			pending_results.insert(pending_results.size(), res);
		end else begin
			merge_bond_entry({site_a, site_b}, frame_end);
		end
		gap = 0;
		if ((pace == PACE_SEND_GAPS && $urandom_range(0, 99) < 66) ||
				(pace == PACE_BOTH && $urandom_range(0, 99) < 12))
			gap = $urandom_range(1, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Bond entry; the bin field is a don't-care here, so let it toggle.
	task automatic send_bond(bit [blt_pkg::KEY_W-1:0] key, bit frame_end);
		send_item(blt_pkg::OP_ENTRY, key[15:8], key[7:0], frame_end,
			14'($urandom_range(0, 16383)));
	endtask

	// Histogram read; site and last fields are ignored by the block, so randomise them.
	task automatic read_bin(logic [13:0] bin);
		send_item(blt_pkg::OP_HIST, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), bin);
	endtask

	// Extremes of both keys, a match, breaks by skipping and by leftovers at frame end,
	// an unsorted frame, repeated keys, a one-entry frame and reads of both end bins.
	task automatic test_directed();
		read_bin(14'd0);
		read_bin(14'h3FFF);
		send_bond(16'h0000, 1'b0);
		send_bond(16'h00FF, 1'b0);
		send_bond(16'hFF00, 1'b0);
		send_bond(16'hFFFF, 1'b1);
		send_bond(16'h0000, 1'b0);
		send_bond(16'h00C8, 1'b0);
		read_bin(14'd1);
		send_bond(16'hFFFF, 1'b1);
		read_bin(14'd1);
		send_bond(16'h0A0A, 1'b0);
		send_bond(16'h0505, 1'b0);
		send_bond(16'h0A0A, 1'b1);
		send_bond(16'h0505, 1'b0);
		send_bond(16'h0505, 1'b0);
		send_bond(16'h0A0A, 1'b1);
		send_bond(16'h0A0A, 1'b1);
		read_bin(14'd1);
		read_bin(14'd2);
		read_bin(14'd3);
	endtask

	// One frame longer than the list store: the excess is dropped and flagged, and the
	// dropped last entry still closes the frame. The next short frame drains the rest.
	task automatic test_list_overflow();
		pace <= PACE_RECV_STALLS;
		for (int unsigned i = 0; i < blt_pkg::MAX_BONDS_DEF + 6; i++)
			send_bond(16'(i * 61), i == blt_pkg::MAX_BONDS_DEF + 5);
		send_bond(16'd61, 1'b0);
		send_bond(16'd122, 1'b0);
		send_bond(16'hFFFF, 1'b1);
		read_bin(14'd1);
		read_bin(14'd2);
		pace <= PACE_FREE;
	endtask

	// Hold the result side off for a long stretch while requests keep coming, so the
	// output fills and the input stalls.
	task automatic test_output_backpressure();
		hold_req <= !hold_req;
		for (int i = 0; i < 24; i++) begin
			if (i % 4 == 3)
				send_bond(16'($urandom_range(0, 15)), 1'b1);
			else
				read_bin(14'($urandom_range(0, 4)));
		end
	endtask

	// Mostly well-formed frame sequences: carry most bonds over from the frame before,
	// add a few new ones (often from a small pool so they recur), keep sorted. Mix in
	// unsorted frames, noise frames and histogram reads.
	task automatic test_random_frames();
		bit [blt_pkg::KEY_W-1:0] fresh [$];
		bit [blt_pkg::KEY_W-1:0] frame_keys [$];
		bit [blt_pkg::KEY_W-1:0] k;
		int unsigned sent;
		int unsigned pos;
		int unsigned x;
		int unsigned y;
		pace_t p;
		for (int ph = 0; ph < 4; ph++) begin
			p = pace_t'(ph);
			pace <= p;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				fresh.delete();
				frame_keys.delete();
				if ($urandom_range(0, 11) == 0) begin
					// noise: random keys, unsorted
					repeat ($urandom_range(1, 8))
						frame_keys.insert(frame_keys.size(), 16'($urandom));
				end else begin
					foreach (prior_frame[i])
						if ($urandom_range(0, 3) != 0)
							fresh.insert(fresh.size(), prior_frame[i]);
					repeat ($urandom_range(0, 6)) begin
						if ($urandom_range(0, 1) != 0)
							fresh.insert(fresh.size(),
								{8'($urandom_range(0, 7)), 8'($urandom_range(0, 7))});
						else
							fresh.insert(fresh.size(), 16'($urandom));
					end
					if (fresh.size() == 0)
						fresh.insert(0, 16'($urandom));
					foreach (fresh[i]) begin
						k = fresh[i];
						pos = 0;
						while (pos < frame_keys.size() && frame_keys[pos] < k)
							pos++;
						frame_keys.insert(pos, k);
					end
					while (frame_keys.size() > FRAME_CAP)
						void'(frame_keys.pop_back());
					// occasionally swap two entries to break the ordering
					if (frame_keys.size() > 1 && $urandom_range(0, 9) == 0) begin
						x = $urandom_range(0, frame_keys.size() - 1);
						y = $urandom_range(0, frame_keys.size() - 1);
						k = frame_keys[x];
						frame_keys[x] = frame_keys[y];
						frame_keys[y] = k;
					end
				end
				foreach (frame_keys[i]) begin
					if ($urandom_range(0, 99) < 12) begin
						if ($urandom_range(0, 9) == 0)
							read_bin(14'($urandom_range(0, 16383)));
						else
							read_bin(14'($urandom_range(0, 20)));
						sent++;
					end
					send_bond(frame_keys[i], i == frame_keys.size() - 1);
					sent++;
				end
				prior_frame = frame_keys;
			end
		end
		pace <= PACE_FREE;
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("mismatch on %s in result %0d: expected %0h, got %0h",
			field, results_seen, want, got);
		mismatch_count++;
	endtask

	// Compare every result taken with the oldest expectation, field by field.
	always @(posedge clk) begin : check_results
		bond_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result value", '0, m_tdata[31:0]);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("kind", 32'(want.kind), 32'(m_tuser));
				if (m_tdata[31:0] !== want.value)
					report_mismatch("value", want.value, m_tdata[31:0]);
				if (m_tdata[32] !== want.overflow)
					report_mismatch("overflow", 32'(want.overflow), 32'(m_tdata[32]));
			end
			results_seen++;
		end
	end

	// Result side: a requested hold-off takes priority, else stall by the current pace.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if ((pace == PACE_RECV_STALLS && $urandom_range(0, 99) < 66) ||
				(pace == PACE_BOTH && $urandom_range(0, 99) < 12)) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Abandon the run if no request moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("bond_lifetime_merge_tracker_core test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = blt_pkg::OP_ENTRY;
		s_tlast  = 1'b0;
		s_tdata  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_list_overflow();
		test_output_backpressure();
		test_random_frames();

		s_tvalid <= 1'b0;
		pace     <= PACE_FREE;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("bond_lifetime_merge_tracker_core test passed");
		else
			$display("bond_lifetime_merge_tracker_core test failed");
		$finish;
	end

endmodule

/* bond_lifetime_merge_tracker_core.f */
rtl/blt_pkg.sv
rtl/blt_bond_list.sv
rtl/blt_life_table.sv
rtl/blt_hist.sv
rtl/bond_lifetime_merge_tracker_core.sv
test/tb_top.sv
